### rtl/trs_pkg.sv
package trs_pkg;

    localparam int unsigned DEF_MAX_TASKS = 8;
    localparam logic [31:0] DELAY_INFINITE = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        MODE_TICK    = 4'd0,
        MODE_PICK    = 4'd1,
        MODE_RUN     = 4'd2,
        MODE_CREATE  = 4'd3,
        MODE_SLEEP   = 4'd4,
        MODE_WAIT    = 4'd5,
        MODE_NOTIFY  = 4'd6,
        MODE_TAKE    = 4'd7,
        MODE_SUSPEND = 4'd8,
        MODE_RESUME  = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        ST_READY     = 2'd0,
        ST_SLEEPING  = 2'd1,
        ST_WAITING   = 2'd2,
        ST_SUSPENDED = 2'd3
    } tstate_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCAN_RD,
        PH_SCAN_EV,
        PH_ENT_RD,
        PH_ENT_WR,
        PH_STAT_RD,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [2:0]  task_index;
        logic [31:0] amount;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  task_out;
        logic [31:0] value_out;
        logic [31:0] tick_now;
        logic [31:0] run_max;
        logic [31:0] run_total;
        logic [31:0] overrun_count;
        logic [31:0] call_count;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  state;
        logic        inf;
        logic [31:0] wake;
        logic [31:0] notify;
        logic [31:0] budget;
    } ctl_ent_t;

    typedef struct packed {
        logic [31:0] max_run;
        logic [31:0] total_run;
        logic [31:0] overruns;
        logic [31:0] picks;
    } stat_ent_t;

endpackage

### rtl/task_ready_scheduler.sv
// Each transaction takes one command and produces exactly one result, shown
// for a single cycle with done high; the receiver cannot stall it. busy is
// high while a command is processed, and a new command is accepted only while
// busy is low. Tick and pick walk the task table one slot at a time through a
// registered-read memory, reading each slot and then evaluating it. No
// clearing pass is needed after reset.
module task_ready_scheduler
    import trs_pkg::*;
#(
    parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);

    ctl_ent_t  ctl_mem  [MAX_TASKS];
    stat_ent_t stat_mem [MAX_TASKS];

    phase_t      phase_reg, phase_next;
    cmd_t        cmd_reg, cmd_next;
    logic [31:0] tick_reg, tick_next;
    logic [CW-1:0] used_reg, used_next;
    logic        cur_valid_reg, cur_valid_next;
    logic [AW-1:0] cur_slot_reg, cur_slot_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic        found_reg, found_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [31:0] value_reg, value_next;
    logic        done_reg, done_next;
    rsp_t        rsp_reg, rsp_next;

    logic [AW-1:0] rd_addr;
    ctl_ent_t    ctl_rd;
    stat_ent_t   stat_rd;
    logic        ctl_we, stat_we;
    logic [AW-1:0] wr_addr;
    ctl_ent_t    ctl_wd;
    stat_ent_t   stat_wd;

    always_ff @(posedge clk)
    begin
        if (ctl_we)
        begin
            ctl_mem[wr_addr] <= ctl_wd;
        end
        if (stat_we)
        begin
            stat_mem[wr_addr] <= stat_wd;
        end
        ctl_rd  <= ctl_mem[rd_addr];
        stat_rd <= stat_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            used_reg      <= '0;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            used_reg      <= used_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        scan_reg  <= scan_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
        value_reg <= value_next;
        rsp_reg   <= rsp_next;
    end

    logic cur_ok, idx_ok;
    logic [31:0] diff;
    logic [CW-1:0] cur_ext;

    assign cur_ext = CW'(cur_slot_reg);
    assign cur_ok  = cur_valid_reg && (cur_ext < used_reg);
    assign idx_ok  = (32'(cmd_reg.task_index) < 32'(used_reg));
    assign diff    = tick_reg - ctl_rd.wake;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    case (cmd.mode)
                        MODE_TICK, MODE_PICK: phase_next = PH_SCAN_RD;
                        MODE_CREATE:          phase_next = PH_ENT_WR;
                        default:              phase_next = PH_ENT_RD;
                    endcase
                end
            end
            PH_SCAN_RD:
            begin
                phase_next = (scan_reg < used_reg) ? PH_SCAN_EV : PH_STAT_RD;
            end
            PH_SCAN_EV:
            begin
                if (cmd_reg.mode == MODE_PICK && ctl_rd.state == ST_READY)
                begin
                    phase_next = PH_ENT_WR;
                end
                else
                begin
                    phase_next = PH_SCAN_RD;
                end
            end
            PH_ENT_RD:  phase_next = PH_ENT_WR;
            PH_ENT_WR:  phase_next = PH_STAT_RD;
            PH_STAT_RD: phase_next = PH_DONE;
            PH_DONE:    phase_next = PH_IDLE;
            default:    phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        tick_next      = tick_reg;
        used_next      = used_reg;
        cur_valid_next = cur_valid_reg;
        cur_slot_next  = cur_slot_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        rd_addr        = slot_reg;
        ctl_we         = 1'b0;
        stat_we        = 1'b0;
        wr_addr        = slot_reg;
        ctl_wd         = ctl_rd;
        stat_wd        = stat_rd;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    scan_next  = '0;
                    value_next = '0;
                    found_next = 1'b0;
                    slot_next  = '0;
                    if (cmd.mode == MODE_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    if (cmd.mode == MODE_PICK)
                    begin
                        cur_valid_next = 1'b0;
                    end
                end
            end
            PH_SCAN_RD:
            begin
                rd_addr = scan_reg[AW-1:0];
                if (scan_reg >= used_reg && cmd_reg.mode == MODE_TICK && cur_ok)
                begin
                    found_next = 1'b1;
                    slot_next  = cur_slot_reg;
                end
            end
            PH_SCAN_EV:
            begin
                wr_addr   = scan_reg[AW-1:0];
                scan_next = scan_reg + CW'(1);
                if (cmd_reg.mode == MODE_TICK)
                begin
                    if ((ctl_rd.state == ST_SLEEPING || ctl_rd.state == ST_WAITING)
                        && !ctl_rd.inf && !diff[31])
                    begin
                        ctl_wd.state = ST_READY;
                        ctl_we       = 1'b1;
                    end
                end
                else if (ctl_rd.state == ST_READY)
                begin
                    found_next     = 1'b1;
                    slot_next      = scan_reg[AW-1:0];
                    cur_valid_next = 1'b1;
                    cur_slot_next  = scan_reg[AW-1:0];
                    rd_addr        = scan_reg[AW-1:0];
                end
            end
            PH_ENT_RD:
            begin
                case (cmd_reg.mode)
                    MODE_RUN, MODE_SLEEP, MODE_WAIT, MODE_TAKE, MODE_SUSPEND:
                    begin
                        found_next = cur_ok;
                        slot_next  = cur_slot_reg;
                        rd_addr    = cur_slot_reg;
                    end
                    MODE_NOTIFY, MODE_RESUME:
                    begin
                        found_next = idx_ok;
                        slot_next  = AW'(cmd_reg.task_index);
                        rd_addr    = AW'(cmd_reg.task_index);
                    end
                    default:
                    begin
                        found_next = 1'b0;
                    end
                endcase
            end
            PH_ENT_WR:
            begin
                if (cmd_reg.mode == MODE_CREATE)
                begin
                    if (used_reg < CW'(MAX_TASKS))
                    begin
                        found_next    = 1'b1;
                        slot_next     = used_reg[AW-1:0];
                        wr_addr       = used_reg[AW-1:0];
                        ctl_wd        = '{state: ST_READY, inf: 1'b0, wake: '0,
                                          notify: '0, budget: cmd_reg.amount};
                        stat_wd       = '0;
                        ctl_we        = 1'b1;
                        stat_we       = 1'b1;
                        used_next     = used_reg + CW'(1);
                    end
                end
                else if (found_reg)
                begin
                    case (cmd_reg.mode)
                        MODE_PICK:
                        begin
                            stat_wd.picks = stat_rd.picks + 32'd1;
                            stat_we       = 1'b1;
                        end
                        MODE_RUN:
                        begin
                            if (cmd_reg.amount > stat_rd.max_run)
                            begin
                                stat_wd.max_run = cmd_reg.amount;
                            end
                            if (cmd_reg.amount > ctl_rd.budget)
                            begin
                                stat_wd.overruns = stat_rd.overruns + 32'd1;
                            end
                            stat_wd.total_run = stat_rd.total_run + cmd_reg.amount;
                            stat_we = 1'b1;
                        end
                        MODE_SLEEP, MODE_WAIT:
                        begin
                            ctl_wd.state = (cmd_reg.mode == MODE_SLEEP) ? ST_SLEEPING
                                                                        : ST_WAITING;
                            ctl_wd.wake  = tick_reg + cmd_reg.amount;
                            ctl_wd.inf   = (cmd_reg.amount == DELAY_INFINITE);
                            if (cmd_reg.mode == MODE_WAIT)
                            begin
                                ctl_wd.notify = '0;
                            end
                            ctl_we = 1'b1;
                        end
                        MODE_TAKE:
                        begin
                            value_next    = ctl_rd.notify;
                            ctl_wd.notify = '0;
                            ctl_we        = 1'b1;
                        end
                        MODE_SUSPEND:
                        begin
                            ctl_wd.state = ST_SUSPENDED;
                            ctl_we       = 1'b1;
                        end
                        MODE_NOTIFY:
                        begin
                            ctl_wd.notify = ctl_rd.notify | cmd_reg.amount;
                            if (ctl_rd.state == ST_WAITING)
                            begin
                                ctl_wd.state = ST_READY;
                            end
                            ctl_we = 1'b1;
                        end
                        MODE_RESUME:
                        begin
                            if (ctl_rd.state == ST_SUSPENDED)
                            begin
                                ctl_wd.state = ST_READY;
                            end
                            ctl_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PH_STAT_RD:
            begin
                rd_addr = slot_reg;
            end
            PH_DONE:
            begin
                done_next              = 1'b1;
                rsp_next.found         = found_reg;
                rsp_next.task_out      = found_reg ? 3'(slot_reg) : 3'd0;
                rsp_next.value_out     = value_reg;
                rsp_next.tick_now      = tick_reg;
                rsp_next.run_max       = found_reg ? stat_rd.max_run : '0;
                rsp_next.run_total     = found_reg ? stat_rd.total_run : '0;
                rsp_next.overrun_count = found_reg ? stat_rd.overruns : '0;
                rsp_next.call_count    = found_reg ? stat_rd.picks : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (phase_reg != PH_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    property p_done_after_work;
        @(posedge clk) disable iff (!rst_n) done |-> $past(phase_reg == PH_DONE);
    endproperty
    a_done_after_work: assert property (p_done_after_work)
        else $error("result without a finished command");

    property p_used_bound;
        @(posedge clk) disable iff (!rst_n) used_reg <= CW'(MAX_TASKS);
    endproperty
    a_used_bound: assert property (p_used_bound)
        else $error("task count beyond table size");

    property p_tick_step;
        @(posedge clk) disable iff (!rst_n)
            (tick_reg != $past(tick_reg)) |-> ($past(phase_reg) == PH_IDLE);
    endproperty
    a_tick_step: assert property (p_tick_step)
        else $error("tick count changed mid-command");

    property p_found_task;
        @(posedge clk) disable iff (!rst_n)
            (done && !rsp.found) |-> (rsp.task_out == 3'd0 && rsp.call_count == '0);
    endproperty
    a_found_task: assert property (p_found_task)
        else $error("stale fields on empty result");

endmodule
